// File: hw/rtl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants for the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

    localparam int unsigned TickW   = 32;
    localparam int unsigned CfgW    = 16;
    localparam int unsigned CfgIdxW = 8;
    localparam int unsigned EventW  = 2;

    // Register indexes on the configuration port
    localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 8'd0;
    localparam logic [CfgIdxW-1:0] CFG_DOUBLE   = 8'd1;
    localparam logic [CfgIdxW-1:0] CFG_HOLD     = 8'd2;

    // Reset values of the timing registers
    localparam logic [CfgW-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [CfgW-1:0] DOUBLE_RST   = 16'd300;
    localparam logic [CfgW-1:0] HOLD_RST     = 16'd800;

    // Event codes reported per transaction
    localparam logic [EventW-1:0] EV_NONE   = 2'd0;
    localparam logic [EventW-1:0] EV_SINGLE = 2'd1;
    localparam logic [EventW-1:0] EV_DOUBLE = 2'd2;
    localparam logic [EventW-1:0] EV_HOLD   = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_PRESSED = 4'b0010,
        PH_WAIT    = 4'b0100,
        PH_HELD    = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [CfgW-1:0] debounce_ticks;
        logic [CfgW-1:0] double_window_ticks;
        logic [CfgW-1:0] hold_ticks;
    } t_cfg;

endpackage

// File: hw/rtl/bcc_core.sv
// ----------------------------------------------------------------------------
// bcc_core
// Debounce and click state machine; updates state on each step strobe and
// presents the event code for the current sample combinationally.
// ----------------------------------------------------------------------------
module bcc_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_raw_level,
    input  logic [bcc_pkg::TickW-1:0]     i_now_ticks,
    input  bcc_pkg::t_cfg                 i_cfg,
    output logic [bcc_pkg::EventW-1:0]    o_event_code
);
    import bcc_pkg::*;

    logic             r_stable, n_stable;
    logic             r_prev_raw, n_prev_raw;
    logic [TickW-1:0] r_change_stamp, n_change_stamp;
    logic [TickW-1:0] r_press_stamp, n_press_stamp;
    logic [TickW-1:0] r_release_stamp, n_release_stamp;
    t_phase           r_phase, n_phase;

    logic             raw_chg;
    logic             deb_ok;
    logic             stable_chg;
    logic             hold_ok;
    logic             win_ok;
    logic [TickW-1:0] dt_change;
    logic [TickW-1:0] dt_press;
    logic [TickW-1:0] dt_release;

    // Wrapping elapsed times against the old stamps. A stamp that is
    // refreshed this step gives zero elapsed time, which never passes a
    // strict compare, so all three compares run in parallel.
    assign dt_change  = i_now_ticks - r_change_stamp;
    assign dt_press   = i_now_ticks - r_press_stamp;
    assign dt_release = i_now_ticks - r_release_stamp;

    assign raw_chg    = i_raw_level != r_prev_raw;
    assign deb_ok     = !raw_chg && (dt_change > {{(TickW-CfgW){1'b0}}, i_cfg.debounce_ticks});
    assign stable_chg = deb_ok && (r_stable != i_raw_level);
    assign hold_ok    = dt_press > {{(TickW-CfgW){1'b0}}, i_cfg.hold_ticks};
    assign win_ok     = dt_release > {{(TickW-CfgW){1'b0}}, i_cfg.double_window_ticks};

    always_comb begin
        n_stable        = stable_chg ? i_raw_level : r_stable;
        n_prev_raw      = i_raw_level;
        n_change_stamp  = raw_chg ? i_now_ticks : r_change_stamp;
        n_press_stamp   = r_press_stamp;
        n_release_stamp = r_release_stamp;
        n_phase         = r_phase;
        o_event_code    = EV_NONE;

        if (stable_chg && !i_raw_level) begin
            // new stable press
            n_press_stamp = i_now_ticks;
            if (r_phase == PH_WAIT) begin
                n_phase      = PH_IDLE;
                o_event_code = EV_DOUBLE;
            end else begin
                n_phase = PH_PRESSED;
            end
        end else if (stable_chg && r_phase == PH_HELD) begin
            n_phase = PH_IDLE;
        end else if (stable_chg && r_phase == PH_PRESSED) begin
            n_release_stamp = i_now_ticks;
            n_phase         = PH_WAIT;
        end else begin
            case (r_phase)
                PH_PRESSED: begin
                    if (hold_ok) begin
                        n_phase      = PH_HELD;
                        o_event_code = EV_HOLD;
                    end
                end
                PH_WAIT: begin
                    if (win_ok) begin
                        n_phase      = PH_IDLE;
                        o_event_code = EV_SINGLE;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable        <= 1'b1;
            r_prev_raw      <= 1'b0;
            r_change_stamp  <= '0;
            r_press_stamp   <= '0;
            r_release_stamp <= '0;
            r_phase         <= PH_IDLE;
        end else if (i_step) begin
            r_stable        <= n_stable;
            r_prev_raw      <= n_prev_raw;
            r_change_stamp  <= n_change_stamp;
            r_press_stamp   <= n_press_stamp;
            r_release_stamp <= n_release_stamp;
            r_phase         <= n_phase;
        end
    end

endmodule

// File: hw/rtl/button_click_classifier_unit.sv
// ----------------------------------------------------------------------------
// button_click_classifier_unit
// Debounces an active-low button and classifies single, double and long
// presses from timestamped pin samples.
//
// Each input transaction carries one raw pin sample and a free-running
// 32-bit tick count; each produces exactly one output transaction with an
// event code (none, single, double, long hold). Each sample is captured in
// an input register, goes through the classifier logic (three parallel
// 32-bit wrapping subtract and compare paths plus the click state machine),
// and moves into the output register once that register is empty or being
// drained. With the event side always ready a new sample is accepted every
// cycle. While a result waits downstream the input register can still take
// one more sample; after that the sample side stalls until the output
// drains. Timing registers (debounce, double window, hold) are written
// through the plain write port; the user must write them only while the
// block is idle, as the block itself does not enforce this. Writes to
// unknown indexes are dropped.
// ----------------------------------------------------------------------------
module button_click_classifier_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_raw_level,
    input  logic [bcc_pkg::TickW-1:0]     i_now_ticks,
    // event channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bcc_pkg::EventW-1:0]    o_event_code,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [bcc_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [bcc_pkg::CfgW-1:0]      i_cfg_wdata
);
    import bcc_pkg::*;

    t_cfg              r_cfg;
    logic              r_in_vld;
    logic              r_in_raw;
    logic [TickW-1:0]  r_in_now;
    logic              r_out_vld;
    logic [EventW-1:0] r_out_event;

    logic              in_acc;
    logic              adv;
    logic [EventW-1:0] core_event;

    // The classifier step fires when the captured sample can move into the
    // output register: it is empty or being drained this cycle.
    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;
    assign in_acc     = i_in_valid && o_in_ready;

    assign o_out_valid  = r_out_vld;
    assign o_event_code = r_out_event;

    // Timing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks      <= DEBOUNCE_RST;
            r_cfg.double_window_ticks <= DOUBLE_RST;
            r_cfg.hold_ticks          <= HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE: r_cfg.debounce_ticks      <= i_cfg_wdata;
                CFG_DOUBLE:   r_cfg.double_window_ticks <= i_cfg_wdata;
                CFG_HOLD:     r_cfg.hold_ticks          <= i_cfg_wdata;
                default:      r_cfg                     <= r_cfg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_raw <= i_raw_level;
            r_in_now <= i_now_ticks;
        end
    end

    bcc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (adv),
        .i_raw_level  (r_in_raw),
        .i_now_ticks  (r_in_now),
        .i_cfg        (r_cfg),
        .o_event_code (core_event)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_event <= core_event;
        end
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the button click classifier: feeds timestamped pin
// samples, predicts every event code in-bench, and compares in order.
// ----------------------------------------------------------------------------
module tb;
    import bcc_pkg::*;

    // Cycles without any transaction on either channel before giving up
    localparam int unsigned STALL_LIMIT   = 2000;
    // Indexes outside the register map; writes there must be dropped
    localparam logic [CfgIdxW-1:0] CFG_SPARE_IDX = 8'd3;
    localparam logic [CfgIdxW-1:0] CFG_LAST_IDX  = 8'hFF;
    localparam int unsigned N_DIRECTED    = 23;

    // ------------------------------------------------------------------------
    // Event predictor plus in-order store of the codes still owed by the DUT
    // ------------------------------------------------------------------------
    class click_event_tracker;
        t_cfg              cfg;
        logic              stable_lvl;
        logic              prior_raw;
        logic [TickW-1:0]  change_t;
        logic [TickW-1:0]  press_t;
        logic [TickW-1:0]  release_t;
        t_phase            phase;
        logic [EventW-1:0] owed_events[$];
        int unsigned       mismatches;
        int unsigned       checked;
        int unsigned       seen[4];

        function new();
            cfg.debounce_ticks      = DEBOUNCE_RST;
            cfg.double_window_ticks = DOUBLE_RST;
            cfg.hold_ticks          = HOLD_RST;
            stable_lvl = 1'b1;
            prior_raw  = 1'b0;     // deliberately differs from stable_lvl
            change_t   = '0;
            press_t    = '0;
            release_t  = '0;
            phase      = PH_IDLE;
            mismatches = 0;
            checked    = 0;
            foreach (seen[i]) seen[i] = 0;
        endfunction

        function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
            case (idx)
                CFG_DEBOUNCE: cfg.debounce_ticks      = val;
                CFG_DOUBLE:   cfg.double_window_ticks = val;
                CFG_HOLD:     cfg.hold_ticks          = val;
                default: ;
            endcase
        endfunction

        // One sample in, one event code out; all elapsed times wrap mod 2^32
        function logic [EventW-1:0] classify_sample(logic raw, logic [TickW-1:0] now);
            logic [TickW-1:0] since_change;
            logic [TickW-1:0] since_press;
            logic [TickW-1:0] since_release;
            if (raw != prior_raw) begin
                change_t  = now;
                prior_raw = raw;
            end
            since_change = now - change_t;
            if (since_change > TickW'(cfg.debounce_ticks) && stable_lvl != raw) begin
                stable_lvl = raw;
                if (raw == 1'b0) begin
                    press_t = now;
                    if (phase == PH_WAIT) begin
                        phase = PH_IDLE;
                        return EV_DOUBLE;
                    end
                    phase = PH_PRESSED;
                end else begin
                    // release out of a long hold is silent
                    if (phase == PH_HELD) begin
                        phase = PH_IDLE;
                        return EV_NONE;
                    end
                    if (phase == PH_PRESSED) begin
                        release_t = now;
                        phase     = PH_WAIT;
                    end
                end
            end
            since_press   = now - press_t;
            since_release = now - release_t;
            if (phase == PH_PRESSED && since_press > TickW'(cfg.hold_ticks)) begin
                phase = PH_HELD;
                return EV_HOLD;
            end
            if (phase == PH_WAIT && since_release > TickW'(cfg.double_window_ticks)) begin
                phase = PH_IDLE;
                return EV_SINGLE;
            end
            return EV_NONE;
        endfunction

        function void note_sample(logic raw, logic [TickW-1:0] now);
            logic [EventW-1:0] code;
            code = classify_sample(raw, now);
            seen[code]++;
            owed_events.push_back(code);
        endfunction

        function void check_event(logic [EventW-1:0] got);
            logic [EventW-1:0] want;
            if (owed_events.size() == 0) begin
                $display("%0t: unexpected event, expected none pending, actual %0d",
                         $time, got);
                mismatches++;
                return;
            end
            want = owed_events.pop_front();
            checked++;
            if (got !== want) begin
                $display("%0t: event_code mismatch, expected %0d, actual %0d",
                         $time, want, got);
                mismatches++;
            end
        endfunction

        function int unsigned owed_count();
            return owed_events.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT inputs (known from time zero) and the DUT itself
    // ------------------------------------------------------------------------
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                i_raw_level = 1'b1;
    logic [TickW-1:0]    i_now_ticks = '0;
    logic                i_out_ready = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx   = '0;
    logic [CfgW-1:0]     i_cfg_wdata = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [EventW-1:0]   o_event_code;

    always #10 i_clk = ~i_clk;

    button_click_classifier_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_raw_level  (i_raw_level),
        .i_now_ticks  (i_now_ticks),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_event_code (o_event_code),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    click_event_tracker tracker = new();

    logic [TickW-1:0] tick_now;      // running timestamp for generated samples
    int unsigned      sent = 0;      // samples accepted so far
    int unsigned      settings = 1;  // timing settings exercised (reset one counts)
    bit               gaps_on = 1'b1;
    int               stall_left = 0;
    int unsigned      idle_cycles = 0;

    // ------------------------------------------------------------------------
    // Event side: check every accepted transaction, then decide whether to
    // stall next cycle. All reads here see pre-edge values.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            tracker.check_event(o_event_code);
        end
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= (stall_left == 1);
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(1, 13);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog: any accepted transaction on either channel resets the count
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sample side. Every task is entered right after a rising edge.
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic raw, input logic [TickW-1:0] stamp);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_raw_level <= raw;
        i_now_ticks <= stamp;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_sample(raw, stamp);
        sent++;
    endtask

    // Hold one pin level for span ticks, sampled at random spacing; the last
    // sample lands exactly span ticks after the first so strict compares get
    // hit right on the boundary.
    task automatic hold_level(input logic lvl, input int unsigned span);
        int unsigned left;
        int unsigned step;
        int unsigned cap;
        cap  = (span / 3 > 1) ? span / 3 : 1;
        left = span;
        tick_now = tick_now + $urandom_range(0, 2);
        send_sample(lvl, tick_now);
        while (left != 0) begin
            step = $urandom_range(0, cap);
            if (step > left) step = left;
            tick_now = tick_now + step;
            left     = left - step;
            send_sample(lvl, tick_now);
        end
    endtask

    // Contact bounce: random levels spaced well inside the debounce time
    task automatic chatter(input int unsigned count, input int unsigned deb);
        repeat (count) begin
            tick_now = tick_now + $urandom_range(0, deb / 2 + 1);
            send_sample(1'($urandom_range(0, 1)), tick_now);
        end
    endtask

    // Duration near a threshold: on it, one past it, one short, anywhere up to it, or further past it
    function automatic int unsigned pick_span(input int unsigned thr);
        case ($urandom_range(0, 4))
            0:       return thr;
            1:       return thr + 1;
            2:       return (thr > 0) ? thr - 1 : 0;
            3:       return $urandom_range(0, thr);
            default: return thr + 1 + $urandom_range(0, thr / 2 + 3);
        endcase
    endfunction

    // One user gesture with random timing; mostly well-formed clicks
    task automatic run_gesture();
        int unsigned deb;
        int unsigned win;
        int unsigned hld;
        int unsigned kind;
        deb  = 32'(tracker.cfg.debounce_ticks);
        win  = 32'(tracker.cfg.double_window_ticks);
        hld  = 32'(tracker.cfg.hold_ticks);
        kind = $urandom_range(0, 9);
        chatter($urandom_range(0, 3), deb);
        case (kind)
            0, 1, 2: begin       // single click
                hold_level(1'b0, deb + 1 + $urandom_range(0, hld));
                chatter($urandom_range(0, 2), deb);
                hold_level(1'b1, deb + 1 + pick_span(win));
            end
            3, 4, 5: begin       // double click, second press inside the window
                hold_level(1'b0, deb + 1 + $urandom_range(0, hld / 2));
                chatter($urandom_range(0, 2), deb);
                hold_level(1'b1, deb + 1 + $urandom_range(0, win));
                chatter($urandom_range(0, 2), deb);
                hold_level(1'b0, deb + 1 + $urandom_range(0, hld / 2));
                hold_level(1'b1, deb + 1 + pick_span(win));
            end
            6, 7: begin          // long hold then release
                hold_level(1'b0, deb + 1 + pick_span(hld));
                hold_level(1'b1, deb + 1 + $urandom_range(0, win));
            end
            8: begin             // glitch right around the debounce time
                hold_level(1'($urandom_range(0, 1)), pick_span(deb));
            end
            default: begin       // arbitrary timestamps, every tick bit moves
                repeat ($urandom_range(1, 4)) begin
                    tick_now = $urandom;
                    send_sample(1'($urandom_range(0, 1)), tick_now);
                end
            end
        endcase
    endtask

    // Stop feeding and let every owed event come out before touching registers
    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.owed_count() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Back-to-back register writes, one per cycle, optionally with two writes
    // to unmapped indexes that must leave the timing unchanged
    task automatic program_regs(input logic [CfgW-1:0] deb, input logic [CfgW-1:0] win,
                                input logic [CfgW-1:0] hld, input bit stray);
        logic [CfgIdxW-1:0] idx_list[$];
        logic [CfgW-1:0]    val_list[$];
        idx_list = '{CFG_DEBOUNCE, CFG_DOUBLE, CFG_HOLD};
        val_list = '{deb, win, hld};
        if (stray) begin
            idx_list.push_back(CFG_SPARE_IDX);
            val_list.push_back(16'hFFFF);
            idx_list.push_back(CFG_LAST_IDX);
            val_list.push_back(16'h0000);
        end
        foreach (idx_list[i]) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= idx_list[i];
            i_cfg_wdata <= val_list[i];
            @(posedge i_clk);
            tracker.set_reg(idx_list[i], val_list[i]);
        end
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic run_phase(input int unsigned quota, input bit quiet);
        int unsigned target;
        target = sent + quota;
        while (sent < target) begin
            // idling switched per gesture so there are clean stretches too
            gaps_on = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
            run_gesture();
        end
        drain();
    endtask

    // Hand-built walk through the click machine at reset timing (20/300/800):
    // first released sample after reset, strict debounce and window edges,
    // single, double, long hold and the silent release after a hold.
    logic [TickW-1:0] directed_t[N_DIRECTED] = '{
        0, 30, 40, 60, 61, 100, 121, 421, 422,
        500, 521, 530, 551, 600, 621,
        700, 721, 800, 821, 1621, 1622, 1700, 1721
    };
    logic directed_lvl[N_DIRECTED] = '{
        1, 1, 0, 0, 0, 1, 1, 1, 1,
        0, 0, 1, 1, 0, 0,
        1, 1, 0, 0, 0, 0, 1, 1
    };

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        gaps_on = 1'b1;
        foreach (directed_t[i]) send_sample(directed_lvl[i], directed_t[i]);
        drain();

        tick_now = $urandom;
        program_regs(DEBOUNCE_RST, DOUBLE_RST, HOLD_RST, 1'b1);
        run_phase(300, 1'b0);

        // zero registers: still need one tick of elapsed time
        program_regs(16'd0, 16'd0, 16'd0, 1'b0);
        run_phase(250, 1'b0);

        // all at maximum, starting just short of the tick wrap
        tick_now = 32'hFFFE_0000 + $urandom_range(0, 16'hFFFF);
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        run_phase(250, 1'b0);

        tick_now = 32'hFFFF_FF00 + $urandom_range(0, 8'hFF);
        program_regs(CfgW'($urandom_range(0, 50)), CfgW'($urandom_range(0, 500)),
                     CfgW'($urandom_range(0, 2000)), 1'b0);
        run_phase(300, 1'b0);

        // slow debounce against an instant window and hold
        program_regs(16'hFFFF, 16'd0, 16'd1, 1'b0);
        run_phase(250, 1'b0);

        // tight timing, full rate on both channels to the end
        program_regs(16'd3, 16'd25, 16'd60, 1'b1);
        run_phase(350, 1'b1);

        repeat (6) @(posedge i_clk);
        $display("Ran %0d samples across %0d timing settings, %0d events checked",
                 sent, settings, tracker.checked);
        $display("Expected events: %0d none, %0d single, %0d double, %0d long hold",
                 tracker.seen[EV_NONE], tracker.seen[EV_SINGLE],
                 tracker.seen[EV_DOUBLE], tracker.seen[EV_HOLD]);
        if (tracker.mismatches == 0 && tracker.owed_count() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
